/* rtl/vsag_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vsag_pkg;

  localparam int DIM_BITS = 10;
  localparam int COORD_W  = DIM_BITS + 1;
  localparam int SLICE_W  = DIM_BITS;
  localparam int INDEX_W  = 3 * DIM_BITS;
  localparam int COUNT_W  = 2 * DIM_BITS;
  localparam int PLANE_W  = 2 * COORD_W;
  localparam int PROD_W   = PLANE_W + COORD_W;
  localparam int BYTE_W   = 32;
  localparam int AXIS_W   = 2;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = COORD_W;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_U8   = 2'd0,
    KIND_U16  = 2'd1,
    KIND_RGBA = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_X     = 2'd0,
    CFG_DIM_Y     = 2'd1,
    CFG_ELEM_KIND = 2'd2
  } cfg_idx_e;

  // walker status seen by the sequencer
  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [SLICE_W-1:0] slice;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [COUNT_W-1:0] count;
    logic               pending;
    logic               last_next;
  } walk_t;

  function automatic logic [BYTE_W-1:0] byte_offset_f(logic [INDEX_W-1:0] idx,
                                                      logic [KIND_W-1:0] kind);
    logic [BYTE_W-1:0] w;
    w = BYTE_W'(idx);
    case (kind)
      KIND_U8:  byte_offset_f = w;
      KIND_U16: byte_offset_f = w << 1;
      default:  byte_offset_f = w << 2;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/vsag_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface vsag_in_if;
  import vsag_pkg::*;
  logic               valid;
  logic               ready;
  logic [0:0]         operation;
  logic [AXIS_W-1:0]  axis;
  logic [SLICE_W-1:0] slice_index;
  logic [COORD_W-1:0] u_min;
  logic [COORD_W-1:0] v_min;
  logic [COORD_W-1:0] u_max;
  logic [COORD_W-1:0] v_max;

  modport source (output valid, operation, axis, slice_index, u_min, v_min, u_max, v_max,
                  input ready);
  modport sink (input valid, operation, axis, slice_index, u_min, v_min, u_max, v_max,
                output ready);
endinterface

interface vsag_out_if;
  import vsag_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] element_index;
  logic [BYTE_W-1:0]  byte_offset;
  logic [COUNT_W-1:0] out_position;
  logic               last;
  logic               exhausted;

  modport source (output valid, element_index, byte_offset, out_position, last, exhausted,
                  input ready);
  modport sink (input valid, element_index, byte_offset, out_position, last, exhausted,
                output ready);
endinterface

`default_nettype wire

/* rtl/vsag_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module vsag_mac (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  wire  [vsag_pkg::PLANE_W-1:0]  op_a_i,
  input  wire  [vsag_pkg::COORD_W-1:0]  op_b_i,
  input  wire  [vsag_pkg::INDEX_W-1:0]  addend_i,
  output logic [vsag_pkg::INDEX_W-1:0]  acc_o
);
  import vsag_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [INDEX_W-1:0] acc_d, acc_q;

  assign prod  = PROD_W'(op_a_i) * PROD_W'(op_b_i);
  // index wraps to its width, so only the low product bits matter
  assign acc_d = prod[INDEX_W-1:0] + addend_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* rtl/vsag_walker.sv */
`timescale 1ns / 1ps
`default_nettype none

module vsag_walker (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           load_i,
  input  wire                           advance_i,
  input  wire  [vsag_pkg::AXIS_W-1:0]   axis_i,
  input  wire  [vsag_pkg::SLICE_W-1:0]  slice_i,
  input  wire  [vsag_pkg::COORD_W-1:0]  u_min_i,
  input  wire  [vsag_pkg::COORD_W-1:0]  v_min_i,
  input  wire  [vsag_pkg::COORD_W-1:0]  u_max_i,
  input  wire  [vsag_pkg::COORD_W-1:0]  v_max_i,
  output vsag_pkg::walk_t               walk_o
);
  import vsag_pkg::*;

  logic [AXIS_W-1:0]  axis_q;
  logic [SLICE_W-1:0] slice_q;
  logic [COORD_W-1:0] u_start_q, u_q, u_end_q, v_q, v_end_q;
  logic [COUNT_W-1:0] count_q;
  logic               pending_q;

  logic [COORD_W-1:0] u_inc, v_inc;
  logic               row_wrap, done;
  logic               load_ok;

  assign u_inc    = u_q + COORD_W'(1);
  assign v_inc    = v_q + COORD_W'(1);
  assign row_wrap = (u_inc >= u_end_q);
  assign done     = row_wrap && (v_inc >= v_end_q);

  // axis code 3 and empty rectangles leave nothing pending
  assign load_ok = ((axis_i == AXIS_X) || (axis_i == AXIS_Y) || (axis_i == AXIS_Z))
                   && (u_min_i < u_max_i) && (v_min_i < v_max_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q    <= '0;
      slice_q   <= '0;
      u_start_q <= '0;
      u_q       <= '0;
      u_end_q   <= '0;
      v_q       <= '0;
      v_end_q   <= '0;
      count_q   <= '0;
      pending_q <= 1'b0;
    end else if (load_i) begin
      axis_q    <= axis_i;
      slice_q   <= slice_i;
      u_start_q <= u_min_i;
      u_q       <= u_min_i;
      u_end_q   <= u_max_i;
      v_q       <= v_min_i;
      v_end_q   <= v_max_i;
      count_q   <= '0;
      pending_q <= load_ok;
    end else if (advance_i) begin
      count_q <= count_q + COUNT_W'(1);
      if (row_wrap) begin
        u_q <= u_start_q;
        v_q <= v_inc;
      end else begin
        u_q <= u_inc;
      end
      if (done) begin
        pending_q <= 1'b0;
      end
    end
  end

  assign walk_o.axis      = axis_q;
  assign walk_o.slice     = slice_q;
  assign walk_o.u         = u_q;
  assign walk_o.v         = v_q;
  assign walk_o.count     = count_q;
  assign walk_o.pending   = pending_q;
  assign walk_o.last_next = done;

endmodule

`default_nettype wire

/* rtl/volume_slice_address_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Slice address generator for an x-fastest volume of dim_x by dim_y by any depth.
// in_i takes items: operation start loads axis, slice index and the half-open
// rectangle [u_min,u_max) x [v_min,v_max) and gives no result; operation next
// gives one result on out_o: element index, byte offset, output position, a last
// flag, or exhausted with zero fields when nothing of the request is left.
// The user must set dim_x, dim_y and element_kind on the cfg port only while the
// block is idle; the block itself does not enforce this. A start item leaves
// in_i ready. A next item that yields an address goes through the plane, term A,
// term B and emit states: one shared multiply-add unit forms dim_x*dim_y, then the
// plane term, then the row term, and the result is registered. An exhausted result
// goes from idle straight to emit. The result register lets the next item be
// accepted while a result still waits; if the receiver stalls, a following address
// waits in the sequencer and in_i is not ready until the register frees up.
// Reset clears the request (nothing pending), sets dim_x = dim_y = 1 and the
// element kind to bytes, and empties the result register.
module volume_slice_address_generator (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  vsag_in_if.sink                         in_i,
  vsag_out_if.source                      out_o,
  input  wire                             cfg_we_i,
  input  wire  [vsag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [vsag_pkg::CFG_W-1:0]      cfg_data_i
);
  import vsag_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLANE,
    ST_TERM_A,
    ST_TERM_B,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  logic [COORD_W-1:0] dim_x_q, dim_y_q;
  logic [KIND_W-1:0]  kind_q;

  logic               out_valid_q;
  logic [INDEX_W-1:0] idx_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [COUNT_W-1:0] pos_q;
  logic               last_q, exh_q;
  logic               emit_exh_q;

  walk_t              walk;
  logic               in_acc, is_start, walk_load, walk_adv, emit_go;
  logic               mac_en;
  logic [PLANE_W-1:0] op_a;
  logic [COORD_W-1:0] op_b;
  logic [INDEX_W-1:0] addend, acc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_start   = (in_i.operation == OP_START);
  assign walk_load  = in_acc && is_start;
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign walk_adv   = emit_go && !emit_exh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= COORD_W'(1);
      dim_y_q <= COORD_W'(1);
      kind_q  <= KIND_U8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM_X:     dim_x_q <= cfg_data_i;
        CFG_DIM_Y:     dim_y_q <= cfg_data_i;
        CFG_ELEM_KIND: kind_q  <= cfg_data_i[KIND_W-1:0];
        default:       ;
      endcase
    end
  end

  vsag_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (walk_load),
    .advance_i (walk_adv),
    .axis_i    (in_i.axis),
    .slice_i   (in_i.slice_index),
    .u_min_i   (in_i.u_min),
    .v_min_i   (in_i.v_min),
    .u_max_i   (in_i.u_max),
    .v_max_i   (in_i.v_max),
    .walk_o    (walk)
  );

  // operand select for the shared multiply-add
  always_comb begin
    mac_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    addend = '0;
    case (state_q)
      ST_PLANE: begin
        mac_en = 1'b1;
        op_a   = PLANE_W'(dim_x_q);
        op_b   = dim_y_q;
      end
      ST_TERM_A: begin
        mac_en = 1'b1;
        op_a   = acc[PLANE_W-1:0];
        case (walk.axis)
          AXIS_X: begin
            op_b   = walk.u;
            addend = INDEX_W'(walk.slice);
          end
          AXIS_Y: begin
            op_b   = walk.v;
            addend = INDEX_W'(walk.u);
          end
          default: begin
            op_b   = COORD_W'(walk.slice);
            addend = INDEX_W'(walk.u);
          end
        endcase
      end
      ST_TERM_B: begin
        mac_en = 1'b1;
        op_a   = PLANE_W'(dim_x_q);
        addend = acc;
        case (walk.axis)
          AXIS_Y:  op_b = COORD_W'(walk.slice);
          default: op_b = walk.v;
        endcase
      end
      default: ;
    endcase
  end

  vsag_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (mac_en),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .addend_i (addend),
    .acc_o    (acc)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !is_start) begin
          state_d = walk.pending ? ST_PLANE : ST_EMIT;
        end
      end
      ST_PLANE:  state_d = ST_TERM_A;
      ST_TERM_A: state_d = ST_TERM_B;
      ST_TERM_B: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      emit_exh_q  <= 1'b0;
      idx_q       <= '0;
      byte_q      <= '0;
      pos_q       <= '0;
      last_q      <= 1'b0;
      exh_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && !is_start) begin
        emit_exh_q <= !walk.pending;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
        exh_q       <= emit_exh_q;
        if (emit_exh_q) begin
          idx_q  <= '0;
          byte_q <= '0;
          pos_q  <= '0;
          last_q <= 1'b0;
        end else begin
          idx_q  <= acc;
          byte_q <= byte_offset_f(acc, kind_q);
          pos_q  <= walk.count;
          last_q <= walk.last_next;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.element_index = idx_q;
  assign out_o.byte_offset   = byte_q;
  assign out_o.out_position  = pos_q;
  assign out_o.last          = last_q;
  assign out_o.exhausted     = exh_q;

`ifndef NO_ASSERTIONS
  a_exh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && exh_q |-> (idx_q == '0) && (byte_q == '0) && (pos_q == '0) && !last_q)
    else $error("exhausted result with nonzero fields");

  a_plane_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLANE) |-> walk.pending && !emit_exh_q)
    else $error("address computation started with no request pending");

  a_byte_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> byte_q == byte_offset_f(idx_q, kind_q))
    else $error("byte offset does not match element index");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_adv && walk.last_next |=> !walk.pending && last_q)
    else $error("request still pending after its last element");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> in_i.ready && out_valid_q)
    else $error("sequencer did not return to idle after emitting");
`endif

endmodule

`default_nettype wire

/* tb/volume_slice_address_generator_test.sv */
`timescale 1ns / 1ps

module volume_slice_address_generator_test;
  import vsag_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1120;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int SHOWN_ERRORS = 10;

  // codes outside the package enums that the block still has to handle
  localparam logic [AXIS_W-1:0]  AXIS_NONE = 2'd3;
  localparam logic [KIND_W-1:0]  KIND_WIDE = 2'd3;
  localparam logic [COORD_W-1:0] COORD_TOP = 11'd1024;

  typedef struct {
    logic [INDEX_W-1:0] element_index;
    logic [BYTE_W-1:0]  byte_offset;
    logic [COUNT_W-1:0] out_position;
    logic               last;
    logic               exhausted;
  } addr_result_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx      = CFG_DIM_X;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 result_ready = 1'b0;

  vsag_in_if  item_ch ();
  vsag_out_if addr_ch ();

  assign addr_ch.ready = result_ready;

  volume_slice_address_generator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (item_ch),
    .out_o      (addr_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted register and walker state
  logic [COORD_W-1:0] dim_x_cfg      = 11'd1;
  logic [COORD_W-1:0] dim_y_cfg      = 11'd1;
  logic [KIND_W-1:0]  kind_cfg       = KIND_U8;
  logic [AXIS_W-1:0]  walk_axis      = '0;
  logic [SLICE_W-1:0] walk_slice     = '0;
  logic [COORD_W-1:0] walk_u_start   = '0;
  logic [COORD_W-1:0] walk_u         = '0;
  logic [COORD_W-1:0] walk_u_end     = '0;
  logic [COORD_W-1:0] walk_v         = '0;
  logic [COORD_W-1:0] walk_v_end     = '0;
  logic [COUNT_W-1:0] walk_count     = '0;
  logic               walk_pending   = 1'b0;

  addr_result_t expected_addrs[$];
  addr_result_t seen_addr;
  addr_result_t want_addr;

  int  mismatches  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  int  mood_left   = 0;
  bit  calm_send   = 1'b0;
  bit  calm_recv   = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(9) == 0) return COORD_TOP;
    return COORD_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [COORD_W-1:0] rand_dim();
    if ($urandom_range(1) == 0) return COORD_W'($urandom_range(1, 16));
    return COORD_W'($urandom_range(1, 1024));
  endfunction

  function automatic bit same_addr(addr_result_t a, addr_result_t b);
    return a.element_index === b.element_index && a.byte_offset === b.byte_offset &&
           a.out_position === b.out_position && a.last === b.last &&
           a.exhausted === b.exhausted;
  endfunction

  // update the walker for one accepted item and queue the address it yields
  task automatic advance_walker(op_e op, logic [AXIS_W-1:0] ax, logic [SLICE_W-1:0] slice,
                                logic [COORD_W-1:0] umin, vmin, umax, vmax);
    addr_result_t res;
    logic [63:0]  plane;
    logic [63:0]  idx;
    logic [63:0]  bytes;
    int           shift;
    res = '{default: '0};
    if (op == OP_START) begin
      walk_axis    = ax;
      walk_slice   = slice;
      walk_u_start = umin;
      walk_u       = umin;
      walk_u_end   = umax;
      walk_v       = vmin;
      walk_v_end   = vmax;
      walk_count   = '0;
      walk_pending = (ax != AXIS_NONE) && (umin < umax) && (vmin < vmax);
    end else if (!walk_pending) begin
      res.exhausted = 1'b1;
      expected_addrs.push_back(res);
    end else begin
      plane = 64'(dim_x_cfg) * 64'(dim_y_cfg);
      case (walk_axis)
        AXIS_X: begin
          idx = 64'(walk_slice) + 64'(walk_v) * 64'(dim_x_cfg) + 64'(walk_u) * plane;
        end
        AXIS_Y: begin
          idx = 64'(walk_u) + 64'(walk_slice) * 64'(dim_x_cfg) + 64'(walk_v) * plane;
        end
        default: begin
          idx = 64'(walk_u) + 64'(walk_v) * 64'(dim_x_cfg) + 64'(walk_slice) * plane;
        end
      endcase
      shift = (kind_cfg == KIND_U8) ? 0 : (kind_cfg == KIND_U16) ? 1 : 2;
      res.element_index = idx[INDEX_W-1:0];
      bytes = 64'(res.element_index) << shift;
      res.byte_offset  = bytes[BYTE_W-1:0];
      res.out_position = walk_count;
      walk_count = walk_count + 1'b1;
      walk_u     = walk_u + 1'b1;
      if (walk_u >= walk_u_end) begin
        walk_u = walk_u_start;
        walk_v = walk_v + 1'b1;
        if (walk_v >= walk_v_end) begin
          res.last     = 1'b1;
          walk_pending = 1'b0;
        end
      end
      expected_addrs.push_back(res);
    end
  endtask

  // entered and left at a falling edge; valid stays up for a back-to-back item
  task automatic send_item(op_e op, logic [AXIS_W-1:0] ax, logic [SLICE_W-1:0] slice,
                           logic [COORD_W-1:0] umin, vmin, umax, vmax);
    int gap;
    gap = (calm_send || $urandom_range(99) < 65) ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid       = 1'b1;
    item_ch.operation   = op;
    item_ch.axis        = ax;
    item_ch.slice_index = slice;
    item_ch.u_min       = umin;
    item_ch.v_min       = vmin;
    item_ch.u_max       = umax;
    item_ch.v_max       = vmax;
    do @(posedge clk); while (!item_ch.ready);
    advance_walker(op, ax, slice, umin, vmin, umax, vmax);
    items_sent++;
    @(negedge clk);
  endtask

  // on a next item only the operation counts, so the rest is junk
  task automatic send_next();
    send_item(OP_NEXT, AXIS_W'($urandom_range(0, 3)), SLICE_W'($urandom_range(0, 1023)),
              rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic settle();
    item_ch.valid = 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy,
                               logic [KIND_W-1:0] kind);
    settle();
    cfg_we   = 1'b1;
    cfg_idx  = CFG_DIM_X;
    cfg_data = dx;
    @(posedge clk);
    dim_x_cfg = dx;
    @(negedge clk);
    cfg_idx  = CFG_DIM_Y;
    cfg_data = dy;
    @(posedge clk);
    dim_y_cfg = dy;
    @(negedge clk);
    cfg_idx  = CFG_ELEM_KIND;
    cfg_data = CFG_W'(kind);
    @(posedge clk);
    kind_cfg = kind;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_idle_and_small_walk();
    // nothing loaded yet, then a 2x2 walk on the reset dims and one past the end
    send_next();
    send_item(OP_START, AXIS_Z, 10'd5, 11'd0, 11'd0, 11'd2, 11'd2);
    repeat (5) send_next();
  endtask

  task automatic test_extreme_coords();
    apply_setting(COORD_TOP, COORD_TOP, KIND_RGBA);
    send_item(OP_START, AXIS_X, 10'd1023, 11'd1022, 11'd1023, COORD_TOP, COORD_TOP);
    repeat (2) send_next();
    send_item(OP_START, AXIS_Y, 10'd1023, 11'd1023, 11'd1023, COORD_TOP, COORD_TOP);
    send_next();
    send_item(OP_START, AXIS_Z, 10'd0, 11'd0, 11'd0, 11'd1, 11'd1);
    repeat (2) send_next();
  endtask

  task automatic test_restart_and_empty();
    apply_setting(11'd37, 11'd23, KIND_U16);
    send_item(OP_START, AXIS_X, 10'd7, 11'd0, 11'd0, 11'd4, 11'd4);
    send_next();
    // restart drops the running request and the position counts from zero again
    send_item(OP_START, AXIS_Y, 10'd9, 11'd10, 11'd3, 11'd12, 11'd4);
    repeat (2) send_next();
    send_item(OP_START, AXIS_Z, 10'd1, 11'd6, 11'd0, 11'd6, 11'd5);
    send_next();
    send_item(OP_START, AXIS_X, 10'd1, 11'd0, COORD_TOP, 11'd3, 11'd0);
    send_next();
    send_item(OP_START, AXIS_NONE, 10'd2, 11'd0, 11'd0, 11'd2, 11'd2);
    send_next();
  endtask

  task automatic test_config_mid_request();
    send_item(OP_START, AXIS_Y, 10'd3, 11'd0, 11'd0, 11'd2, 11'd1);
    send_next();
    // new dims and the unnamed kind apply to the rest of the running request
    apply_setting(11'd7, 11'd5, KIND_WIDE);
    repeat (2) send_next();
  endtask

  task automatic test_random_walks();
    int                 per_phase;
    int                 stop_at;
    int                 w;
    int                 h;
    int                 r;
    logic [COORD_W-1:0] umin;
    logic [COORD_W-1:0] vmin;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(11'd1, 11'd1, KIND_U8);
        1: apply_setting(COORD_TOP, COORD_TOP, KIND_RGBA);
        2: apply_setting(COORD_TOP, 11'd1, KIND_U16);
        3: apply_setting(11'd1, COORD_TOP, KIND_U8);
        default: apply_setting(rand_dim(), rand_dim(), KIND_W'($urandom_range(0, 2)));
      endcase
      stop_at = items_sent + per_phase;
      while (items_sent < stop_at) begin
        r = $urandom_range(99);
        if (r < 72) begin
          // well-formed request walked to its end, sometimes cut short
          w = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
          h = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 8);
          umin = ($urandom_range(9) == 0) ? COORD_W'(1024 - w)
                                          : COORD_W'($urandom_range(0, 1024 - w));
          vmin = ($urandom_range(9) == 0) ? COORD_W'(1024 - h)
                                          : COORD_W'($urandom_range(0, 1024 - h));
          send_item(OP_START, AXIS_W'($urandom_range(0, 2)),
                    SLICE_W'($urandom_range(0, 1023)),
                    umin, vmin, umin + COORD_W'(w), vmin + COORD_W'(h));
          for (int k = 0; k < w * h; k++) begin
            if ($urandom_range(99) < 2) break;
            send_next();
          end
          if ($urandom_range(99) < 25) send_next();
          if ($urandom_range(99) < 3) settle();
        end else if (r < 86) begin
          umin = rand_coord();
          vmin = rand_coord();
          case ($urandom_range(2))
            0: send_item(OP_START, AXIS_W'($urandom_range(0, 2)),
                         SLICE_W'($urandom_range(0, 1023)), umin, vmin,
                         COORD_W'($urandom_range(0, umin)), rand_coord());
            1: send_item(OP_START, AXIS_W'($urandom_range(0, 2)),
                         SLICE_W'($urandom_range(0, 1023)), umin, vmin,
                         rand_coord(), COORD_W'($urandom_range(0, vmin)));
            default: send_item(OP_START, AXIS_NONE, SLICE_W'($urandom_range(0, 1023)),
                               umin, vmin, rand_coord(), rand_coord());
          endcase
          repeat ($urandom_range(1, 2)) send_next();
        end else begin
          send_item(op_e'($urandom_range(0, 1)), AXIS_W'($urandom_range(0, 3)),
                    SLICE_W'($urandom_range(0, 1023)),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
      end
    end
  endtask

  // receiver stalls, plus stretches where neither side idles
  always @(negedge clk) begin
    if (mood_left == 0) begin
      calm_send = ($urandom_range(3) == 0);
      calm_recv = ($urandom_range(3) == 0);
      mood_left = $urandom_range(50, 300);
    end else begin
      mood_left--;
    end
    if (stall_left > 0) begin
      result_ready = 1'b0;
      stall_left--;
    end else begin
      result_ready = 1'b1;
      if (!calm_recv && $urandom_range(99) < 20) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && addr_ch.valid && addr_ch.ready) begin
      seen_addr.element_index = addr_ch.element_index;
      seen_addr.byte_offset   = addr_ch.byte_offset;
      seen_addr.out_position  = addr_ch.out_position;
      seen_addr.last          = addr_ch.last;
      seen_addr.exhausted     = addr_ch.exhausted;
      if (expected_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected address: index %0d bytes %0d pos %0d last %0b exh %0b",
                   seen_addr.element_index, seen_addr.byte_offset, seen_addr.out_position,
                   seen_addr.last, seen_addr.exhausted);
      end else begin
        want_addr = expected_addrs.pop_front();
        if (!same_addr(seen_addr, want_addr)) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display({"address mismatch: expected index %0d bytes %0d pos %0d last %0b ",
                      "exh %0b, got index %0d bytes %0d pos %0d last %0b exh %0b"},
                     want_addr.element_index, want_addr.byte_offset,
                     want_addr.out_position, want_addr.last, want_addr.exhausted,
                     seen_addr.element_index, seen_addr.byte_offset,
                     seen_addr.out_position, seen_addr.last, seen_addr.exhausted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("volume_slice_address_generator_test: errors");
      $finish;
    end
  end

  initial begin
    item_ch.valid       = 1'b0;
    item_ch.operation   = OP_START;
    item_ch.axis        = AXIS_X;
    item_ch.slice_index = '0;
    item_ch.u_min       = '0;
    item_ch.v_min       = '0;
    item_ch.u_max       = '0;
    item_ch.v_max       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_idle_and_small_walk();
    test_extreme_coords();
    test_restart_and_empty();
    test_config_mid_request();
    test_random_walks();
    settle();
    if (mismatches == 0 && expected_addrs.size() == 0) begin
      $display("volume_slice_address_generator_test: clean");
    end else begin
      $display("volume_slice_address_generator_test: errors");
    end
    $finish;
  end

endmodule
